FILE: rtl/core/vrrp_pkg.sv
package vrrp_pkg;

  localparam int MAX_GROUPS_DEF = 32;
  localparam logic [11:0] AI_RESET = 12'd100;
  localparam logic [7:0] PRIO_DEFAULT = 8'd100;

  typedef enum logic [2:0] {
    MODE_CREATE = 3'd0,
    MODE_PRIO   = 3'd1,
    MODE_ENABLE = 3'd2,
    MODE_ADVERT = 3'd3,
    MODE_TICK   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_INIT   = 2'd0,
    ST_BACKUP = 2'd1,
    ST_MASTER = 2'd2
  } gstate_t;

  typedef enum logic [2:0] {
    EV_OK     = 3'd0,
    EV_ERR    = 3'd1,
    EV_MASTER = 3'd2,
    EV_BACKUP = 3'd3,
    EV_SENT   = 3'd4,
    EV_IDLE   = 3'd5
  } event_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_MUL,
    S_DONE
  } fsm_t;

  // one table entry; kept master-down interval in centiseconds
  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [1:0]  st;
    logic        en;
    logic [31:0] last_rx;
    logic [31:0] rx_cnt;
    logic [31:0] tx_cnt;
    logic [31:0] m_addr;
    logic [7:0]  m_prio;
    logic [13:0] down_cs;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: rtl/core/vrrp_ram.sv
module vrrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/vrrp_group_state_engine.sv
// create, undefined mode or empty table: accept goes to DONE, whose result is registered out
// a search or tick walks the table group by group through read, data and update;
//   a search ends at its hit, a miss walks every group and ends in DONE
// tick: walks every group, last result from DONE; one transaction at a time
// busy drops in the cycle of the last done strobe; the receiver cannot stall
// rst (synchronous) empties the table and sets the interval register to 100
module vrrp_group_state_engine #(
  parameter int MAX_GROUPS = vrrp_pkg::MAX_GROUPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode,
  input  logic [7:0]  group_id,
  input  logic [7:0]  prio_value,
  input  logic        enable_flag,
  input  logic [7:0]  version_byte,
  input  logic [15:0] pkt_len,
  input  logic [31:0] source_addr,
  input  logic [31:0] now_ms,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data,
  output logic        done,
  output logic [4:0]  slot,
  output logic [7:0]  result_group_id,
  output logic [1:0]  group_state,
  output logic [2:0]  event_res,
  output logic [31:0] count,
  output logic        last
);

  localparam int AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int CW = $clog2(MAX_GROUPS + 1);

  vrrp_pkg::fsm_t state, state_next;
  logic [11:0] ai;
  logic [CW-1:0] gcount;
  logic [CW-1:0] idx;
  logic [2:0] r_mode;
  logic [7:0] r_id, r_prio;
  logic r_en;
  logic r_good;
  logic r_new;
  logic [31:0] r_src, r_now;
  logic [5:0] nres;
  logic [20:0] prod;
  logic [AW-1:0] idx_a;

  logic we;
  vrrp_pkg::entry_t wdata, rdata, e;
  logic ev_v;
  logic [2:0] ev;
  logic [31:0] ev_cnt;

  // held tick result, sent once the next one or the end of the walk is known
  logic cap, emit_p, pend;
  logic [4:0] p_slot;
  logic [7:0] p_id;
  logic [1:0] p_st;
  logic [2:0] p_ev;
  logic [31:0] p_cnt;

  assign idx_a = idx[AW-1:0];
  assign cfg_ready = (state == vrrp_pkg::S_IDLE) && !start;
  assign busy = (state != vrrp_pkg::S_IDLE);

  vrrp_ram #(.WIDTH(vrrp_pkg::ENTRY_W), .DEPTH(MAX_GROUPS)) u_table (
    .clk(clk), .we(we), .waddr(idx_a), .wdata(wdata), .raddr(idx_a), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vrrp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ai <= vrrp_pkg::AI_RESET;
      gcount <= '0;
      idx <= '0;
      nres <= '0;
      pend <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= emit_p || ev_v;
      if (cfg_valid && cfg_ready) begin
        ai <= cfg_data;
      end
      if (state == vrrp_pkg::S_IDLE && start) begin
        r_mode <= mode;
        r_id <= group_id;
        r_prio <= prio_value;
        r_en <= enable_flag;
        r_src <= source_addr;
        r_now <= now_ms;
        r_good <= (pkt_len >= 16'd8) &&
                  (version_byte[7:4] == 4'd2 || version_byte[7:4] == 4'd3);
        r_new <= (mode == vrrp_pkg::MODE_CREATE) && (gcount < CW'(MAX_GROUPS));
        idx <= (mode == vrrp_pkg::MODE_CREATE && gcount < CW'(MAX_GROUPS)) ? gcount : '0;
        if (mode == vrrp_pkg::MODE_CREATE && gcount < CW'(MAX_GROUPS)) begin
          gcount <= gcount + 1'b1;
        end
        nres <= '0;
        pend <= 1'b0;
        e <= '0;
      end
      if (state == vrrp_pkg::S_EVAL) begin
        e <= rdata;
        prod <= (21'd256 - {13'd0, rdata.prio}) * {9'd0, ai};
      end
      if (state == vrrp_pkg::S_MUL) begin
        idx <= idx + 1'b1;
      end
      if (cap) begin
        pend <= 1'b1;
        nres <= nres + 1'b1;
        p_slot <= 5'(idx);
        p_id <= wdata.id;
        p_st <= wdata.st;
        p_ev <= ev;
        p_cnt <= ev_cnt;
      end
      if (emit_p) begin
        slot <= p_slot;
        result_group_id <= p_id;
        group_state <= p_st;
        event_res <= p_ev;
        count <= p_cnt;
        last <= (state_next == vrrp_pkg::S_IDLE);
      end else if (ev_v) begin
        slot <= (ev == vrrp_pkg::EV_ERR || ev == vrrp_pkg::EV_IDLE) ? '0 : 5'(idx);
        result_group_id <= (ev == vrrp_pkg::EV_ERR || ev == vrrp_pkg::EV_IDLE) ?
                           ((ev == vrrp_pkg::EV_IDLE) ? 8'd0 : r_id) : wdata.id;
        group_state <= (ev == vrrp_pkg::EV_ERR || ev == vrrp_pkg::EV_IDLE) ?
                       vrrp_pkg::ST_INIT : wdata.st;
        event_res <= ev;
        count <= ev_cnt;
        last <= (state_next == vrrp_pkg::S_IDLE);
      end
    end
  end

  // per entry: READ presents address, EVAL has data, MUL applies
  always_comb begin
    logic hit, fin, adv_hit;
    logic [31:0] el;
    logic [13:0] dn;
    state_next = state;
    we = 1'b0;
    wdata = e;
    ev_v = 1'b0;
    cap = 1'b0;
    emit_p = 1'b0;
    ev = vrrp_pkg::EV_OK;
    ev_cnt = '0;
    hit = (e.id == r_id);
    adv_hit = hit && e.en;
    fin = (idx + 1'b1 >= gcount);
    el = r_now - e.last_rx;
    dn = 14'(({2'd0, ai} * 14'd3) + 14'(prod[20:8]));
    case (state)
      vrrp_pkg::S_IDLE: begin
        if (start) begin
          state_next = vrrp_pkg::S_DONE;
          if (mode == vrrp_pkg::MODE_CREATE ||
              (mode == vrrp_pkg::MODE_PRIO || mode == vrrp_pkg::MODE_ENABLE ||
               mode == vrrp_pkg::MODE_ADVERT || mode == vrrp_pkg::MODE_TICK) &&
              gcount != '0) begin
            state_next = (mode == vrrp_pkg::MODE_CREATE) ? vrrp_pkg::S_DONE :
                         vrrp_pkg::S_READ;
          end
        end
      end
      vrrp_pkg::S_READ: state_next = vrrp_pkg::S_EVAL;
      vrrp_pkg::S_EVAL: state_next = vrrp_pkg::S_MUL;
      vrrp_pkg::S_MUL: begin
        state_next = fin ? vrrp_pkg::S_DONE : vrrp_pkg::S_READ;
        case (r_mode)
          vrrp_pkg::MODE_PRIO, vrrp_pkg::MODE_ENABLE: begin
            if (hit) begin
              we = 1'b1;
              if (r_mode == vrrp_pkg::MODE_PRIO) begin
                wdata.prio = r_prio;
              end else begin
                wdata.en = r_en;
                wdata.st = r_en ? vrrp_pkg::ST_BACKUP : vrrp_pkg::ST_INIT;
                if (r_en) wdata.down_cs = dn;
              end
              ev_v = 1'b1;
              state_next = vrrp_pkg::S_IDLE;
            end
          end
          vrrp_pkg::MODE_ADVERT: begin
            if (adv_hit && r_good) begin
              we = 1'b1;
              wdata.rx_cnt = e.rx_cnt + 1'b1;
              wdata.last_rx = r_now;
              wdata.m_addr = r_src;
              wdata.m_prio = r_prio;
              if (e.st == vrrp_pkg::ST_BACKUP) begin
                wdata.down_cs = dn;
              end else if (e.st == vrrp_pkg::ST_MASTER &&
                           (r_prio > e.prio || (r_prio == e.prio && r_src != '0))) begin
                wdata.st = vrrp_pkg::ST_BACKUP;
                ev = vrrp_pkg::EV_BACKUP;
              end
              ev_cnt = wdata.rx_cnt;
              ev_v = 1'b1;
              state_next = vrrp_pkg::S_IDLE;
            end
          end
          vrrp_pkg::MODE_TICK: begin
            if (e.en && e.st == vrrp_pkg::ST_BACKUP && el > 32'(e.down_cs) * 32'd10) begin
              we = 1'b1;
              wdata.st = vrrp_pkg::ST_MASTER;
              ev = vrrp_pkg::EV_MASTER;
              cap = (nres < 6'd32);
            end else if (e.en && e.st == vrrp_pkg::ST_MASTER) begin
              we = 1'b1;
              wdata.tx_cnt = e.tx_cnt + 1'b1;
              ev = vrrp_pkg::EV_SENT;
              ev_cnt = wdata.tx_cnt;
              cap = (nres < 6'd32);
            end
            emit_p = cap && pend;
          end
          default: ;
        endcase
      end
      vrrp_pkg::S_DONE: begin
        state_next = vrrp_pkg::S_IDLE;
        ev = vrrp_pkg::EV_ERR;
        if (r_mode == vrrp_pkg::MODE_CREATE && r_new) begin
          we = 1'b1;
          wdata = '0;
          wdata.id = r_id;
          wdata.prio = vrrp_pkg::PRIO_DEFAULT;
          ev = vrrp_pkg::EV_OK;
        end
        if (r_mode == vrrp_pkg::MODE_TICK) ev = vrrp_pkg::EV_IDLE;
        emit_p = (r_mode == vrrp_pkg::MODE_TICK) && pend;
        ev_v = !emit_p;
      end
      default: state_next = vrrp_pkg::S_IDLE;
    endcase
  end

endmodule
